FILE: sv/zctd_pkg.sv
// zctd_pkg: shared types, codes and character tables of the z-character text decoder
`default_nettype none
package zctd_pkg;

	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_CHAR    = 3'd1;
	localparam logic [2:0] KIND_NEWLINE = 3'd2;
	localparam logic [2:0] KIND_ABBREV  = 3'd3;
	localparam logic [2:0] KIND_CLICK   = 3'd4;

	localparam logic CFG_VERSION = 1'b0;
	localparam logic CFG_SKIP    = 1'b1;

	localparam logic [3:0] CFG_VERSION_RESET = 4'd3;

	localparam logic [7:0]  EXT_LOW      = 8'h9b;
	localparam logic [7:0]  CLICK_LOW    = 8'hfc;
	localparam logic [7:0]  CLICK_MID    = 8'hfd;
	localparam logic [7:0]  CLICK_HIGH   = 8'hfe;
	localparam logic [15:0] CODE_QUESTION = 16'h003f;
	localparam logic [15:0] CODE_SPACE    = 16'h0020;
	localparam logic [15:0] CODE_CR       = 16'h000d;

	typedef enum logic [1:0] {
		ESC_NONE   = 2'd0,
		ESC_ABBREV = 2'd1,
		ESC_HIGH   = 2'd2,
		ESC_LOW    = 2'd3
	} esc_t;

	typedef struct packed {
		logic            last;
		logic [2:0][4:0] zc;
	} word_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] char_code;
		logic [6:0]  abbrev_index;
		logic        last_of_word;
		logic        end_of_string;
	} res_t;

	typedef struct packed {
		logic [3:0] story_version;
		logic       skip_extended_map;
	} cfg_t;

	function automatic logic [15:0] latin_map(input logic [7:0] z);
		logic [15:0] r;
		case (z)
			8'h9b: r = 16'h0e4; 8'h9c: r = 16'h0f6; 8'h9d: r = 16'h0fc; 8'h9e: r = 16'h0c4;
			8'h9f: r = 16'h0d6; 8'ha0: r = 16'h0dc; 8'ha1: r = 16'h0df; 8'ha2: r = 16'h0bb;
			8'ha3: r = 16'h0ab; 8'ha4: r = 16'h0eb; 8'ha5: r = 16'h0ef; 8'ha6: r = 16'h0ff;
			8'ha7: r = 16'h0cb; 8'ha8: r = 16'h0cf; 8'ha9: r = 16'h0e1; 8'haa: r = 16'h0e9;
			8'hab: r = 16'h0ed; 8'hac: r = 16'h0f3; 8'had: r = 16'h0fa; 8'hae: r = 16'h0fd;
			8'haf: r = 16'h0c1; 8'hb0: r = 16'h0c9; 8'hb1: r = 16'h0cd; 8'hb2: r = 16'h0d3;
			8'hb3: r = 16'h0da; 8'hb4: r = 16'h0dd; 8'hb5: r = 16'h0e0; 8'hb6: r = 16'h0e8;
			8'hb7: r = 16'h0ec; 8'hb8: r = 16'h0f2; 8'hb9: r = 16'h0f9; 8'hba: r = 16'h0c0;
			8'hbb: r = 16'h0c8; 8'hbc: r = 16'h0cc; 8'hbd: r = 16'h0d2; 8'hbe: r = 16'h0d9;
			8'hbf: r = 16'h0e2; 8'hc0: r = 16'h0ea; 8'hc1: r = 16'h0ee; 8'hc2: r = 16'h0f4;
			8'hc3: r = 16'h0fb; 8'hc4: r = 16'h0c2; 8'hc5: r = 16'h0ca; 8'hc6: r = 16'h0ce;
			8'hc7: r = 16'h0d4; 8'hc8: r = 16'h0db; 8'hc9: r = 16'h0e5; 8'hca: r = 16'h0c5;
			8'hcb: r = 16'h0f8; 8'hcc: r = 16'h0d8; 8'hcd: r = 16'h0e3; 8'hce: r = 16'h0f1;
			8'hcf: r = 16'h0f5; 8'hd0: r = 16'h0c3; 8'hd1: r = 16'h0d1; 8'hd2: r = 16'h0d5;
			8'hd3: r = 16'h0e6; 8'hd4: r = 16'h0c6; 8'hd5: r = 16'h0e7; 8'hd6: r = 16'h0c7;
			8'hd7: r = 16'h0fe; 8'hd8: r = 16'h0f0; 8'hd9: r = 16'h0de; 8'hda: r = 16'h0d0;
			8'hdb: r = 16'h0a3; 8'hdc: r = 16'h153; 8'hdd: r = 16'h152; 8'hde: r = 16'h0a1;
			8'hdf: r = 16'h0bf;
			default: r = CODE_QUESTION;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] a2_char(input logic v1, input logic [4:0] idx);
		logic [7:0] r;
		case (idx)
			5'd0:  r = 8'h20;
			5'd1:  r = v1 ? 8'h30 : 8'h5e;
			5'd2:  r = v1 ? 8'h31 : 8'h30;
			5'd3:  r = v1 ? 8'h32 : 8'h31;
			5'd4:  r = v1 ? 8'h33 : 8'h32;
			5'd5:  r = v1 ? 8'h34 : 8'h33;
			5'd6:  r = v1 ? 8'h35 : 8'h34;
			5'd7:  r = v1 ? 8'h36 : 8'h35;
			5'd8:  r = v1 ? 8'h37 : 8'h36;
			5'd9:  r = v1 ? 8'h38 : 8'h37;
			5'd10: r = v1 ? 8'h39 : 8'h38;
			5'd11: r = v1 ? 8'h2e : 8'h39;
			5'd12: r = v1 ? 8'h2c : 8'h2e;
			5'd13: r = v1 ? 8'h21 : 8'h2c;
			5'd14: r = v1 ? 8'h3f : 8'h21;
			5'd15: r = v1 ? 8'h5f : 8'h3f;
			5'd16: r = v1 ? 8'h23 : 8'h5f;
			5'd17: r = v1 ? 8'h27 : 8'h23;
			5'd18: r = v1 ? 8'h22 : 8'h27;
			5'd19: r = v1 ? 8'h2f : 8'h22;
			5'd20: r = v1 ? 8'h5c : 8'h2f;
			5'd21: r = v1 ? 8'h3c : 8'h5c;
			5'd22: r = 8'h2d;
			5'd23: r = 8'h3a;
			5'd24: r = 8'h28;
			default: r = 8'h29;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/zctd_front.sv
// zctd_front: input word queue that splits each word into its z-characters and end flag
`default_nettype none
module zctd_front import zctd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] packed_word,
	output logic             q_valid,
	output word_t            q_data,
	input  wire logic        q_pop
);

	word_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	word_t      entry;

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_data   = mem_q[rd_ptr_q];

	always_comb begin
		entry.last  = packed_word[15];
		entry.zc[0] = packed_word[14:10];
		entry.zc[1] = packed_word[9:5];
		entry.zc[2] = packed_word[4:0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/zctd_back.sv
// zctd_back: z-character sequencer with shift and escape state and a registered result
`default_nettype none
module zctd_back import zctd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  q_valid,
	input  wire word_t q_data,
	output logic       q_pop,
	output logic       res_valid,
	input  wire logic  res_ready,
	output res_t       res
);

	logic [1:0] k_q;
	logic [1:0] shift_now_q;
	logic [1:0] lock_q;
	esc_t       esc_q;
	logic [4:0] prev_q;
	logic       out_valid_q;
	res_t       out_q;

	logic       adv;
	logic       last_zc;
	logic [4:0] zc;
	logic [3:0] ver;
	logic [7:0] zz;
	logic [4:0] pm1;
	logic [2:0] shift_sum;
	logic [4:0] idx;
	logic [1:0] shift_nx;
	logic [1:0] lock_nx;
	esc_t       esc_nx;
	res_t       r;

	assign ver       = cfg.story_version;
	assign adv       = q_valid && (!out_valid_q || res_ready);
	assign last_zc   = (k_q == 2'd2);
	assign q_pop     = adv && last_zc;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		case (k_q)
			2'd0:    zc = q_data.zc[0];
			2'd1:    zc = q_data.zc[1];
			default: zc = q_data.zc[2];
		endcase
	end

	always_comb begin
		zz        = {prev_q[2:0], zc};
		pm1       = (prev_q != 5'd0) ? prev_q - 5'd1 : 5'd0;
		shift_sum = {1'b0, lock_q} + {2'b00, zc[0]} + 3'd1;
		idx       = zc - 5'd6;
		shift_nx  = shift_now_q;
		lock_nx   = lock_q;
		esc_nx    = esc_q;
		r.kind          = KIND_NONE;
		r.char_code     = '0;
		r.abbrev_index  = '0;
		r.last_of_word  = last_zc;
		r.end_of_string = last_zc && q_data.last;
		case (esc_q)
			ESC_NONE: begin
				shift_nx = lock_q;
				if (shift_now_q == 2'd2 && zc == 5'd6) begin
					esc_nx = ESC_HIGH;
				end else if (ver == 4'd1 && zc == 5'd1) begin
					r.kind      = KIND_NEWLINE;
					r.char_code = CODE_CR;
				end else if (ver >= 4'd2 && shift_now_q == 2'd2 && zc == 5'd7) begin
					r.kind      = KIND_NEWLINE;
					r.char_code = CODE_CR;
				end else if (zc >= 5'd6) begin
					r.kind = KIND_CHAR;
					case (shift_now_q)
						2'd0:    r.char_code = 16'h0061 + {11'd0, idx};
						2'd1:    r.char_code = 16'h0041 + {11'd0, idx};
						default: r.char_code = {8'd0, a2_char(ver == 4'd1, idx)};
					endcase
				end else if (zc == 5'd0) begin
					r.kind      = KIND_CHAR;
					r.char_code = CODE_SPACE;
				end else if (ver >= 4'd2 && zc == 5'd1) begin
					esc_nx = ESC_ABBREV;
				end else if (ver >= 4'd3 && zc <= 5'd3) begin
					esc_nx = ESC_ABBREV;
				end else begin
					shift_nx = (shift_sum >= 3'd3) ? 2'(shift_sum - 3'd3) : shift_sum[1:0];
					if (ver <= 4'd2 && zc >= 5'd4) begin
						lock_nx = shift_nx;
					end
				end
			end
			ESC_ABBREV: begin
				r.kind         = KIND_ABBREV;
				r.abbrev_index = {pm1[1:0], zc};
				esc_nx         = ESC_NONE;
			end
			ESC_HIGH: begin
				esc_nx = ESC_LOW;
			end
			default: begin
				esc_nx = ESC_NONE;
				if (prev_q >= 5'd24) begin
					r.kind      = KIND_CHAR;
					r.char_code = CODE_QUESTION;
				end else if (zz == CLICK_LOW || zz == CLICK_MID || zz == CLICK_HIGH) begin
					r.kind      = KIND_CLICK;
					r.char_code = {8'd0, zz};
				end else if (zz >= EXT_LOW && !cfg.skip_extended_map) begin
					r.kind      = KIND_CHAR;
					r.char_code = latin_map(zz);
				end else begin
					r.kind      = KIND_CHAR;
					r.char_code = {8'd0, zz};
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= 2'd0;
			shift_now_q <= 2'd0;
			lock_q      <= 2'd0;
			esc_q       <= ESC_NONE;
			prev_q      <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				k_q <= last_zc ? 2'd0 : k_q + 2'd1;
				if (last_zc && q_data.last) begin
					shift_now_q <= 2'd0;
					lock_q      <= 2'd0;
					esc_q       <= ESC_NONE;
					prev_q      <= 5'd0;
				end else begin
					shift_now_q <= shift_nx;
					lock_q      <= lock_nx;
					esc_q       <= esc_nx;
					prev_q      <= zc;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/zchar_text_decoder_top.sv
// zchar_text_decoder_top: z-character text decoder with config registers, word queue and sequencer
//
// input channel: in_valid / in_ready carry one packed_word per item, three 5-bit
// z-characters (bits 14..10 first) and an end-of-string flag in bit 15.
// output channel: out_valid / out_ready carry one result item per z-character:
// kind, char_code, abbrev_index, last_of_word, end_of_string.
// every input item yields exactly three result items in order.
// config: cfg_we writes cfg_data into register cfg_index (0 story_version,
// 1 skip_extended_map); the user must write only while idle; not enforced by the block.
// with the queue empty, a word is stored in the queue entry and its first result is
// then registered in the result register; the other two follow in order.
// the sequencer decodes one z-character per cycle while out_ready does not hold
// it back, through the shared decode logic and result register.
// a two-entry word queue decouples input acceptance from decoding, so new
// words are taken while results are still being produced or wait for out_ready.
// when out_ready is low with a result pending, the result register holds and
// decoding pauses; the queue keeps accepting until full.
// reset: queue empty, no result pending, shift, lock, escape and previous
// z-character cleared, story_version 3, skip_extended_map 0.
`default_nettype none
module zchar_text_decoder_top import zctd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] packed_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [15:0]      char_code,
	output logic [6:0]       abbrev_index,
	output logic             last_of_word,
	output logic             end_of_string
);

	cfg_t  cfg_q;
	logic  q_valid;
	word_t q_data;
	logic  q_pop;
	res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.story_version     <= CFG_VERSION_RESET;
			cfg_q.skip_extended_map <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VERSION: cfg_q.story_version     <= cfg_data;
				CFG_SKIP:    cfg_q.skip_extended_map <= cfg_data[0];
				default:     cfg_q                   <= cfg_q;
			endcase
		end
	end

	zctd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.packed_word (packed_word),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.q_pop       (q_pop)
	);

	zctd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign kind          = res.kind;
	assign char_code     = res.char_code;
	assign abbrev_index  = res.abbrev_index;
	assign last_of_word  = res.last_of_word;
	assign end_of_string = res.end_of_string;

endmodule
`default_nettype wire
